/* rtl/ocsr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Octagon span rasterizer package
// Shared widths, types, register indexes and the chamfer table.
// ----------------------------------------------------------------------------
package ocsr_pkg;

  localparam int unsigned MaxRadiusLimit = 64;
  localparam int unsigned CenterW        = 12;
  localparam int unsigned RadiusW        = 7;
  localparam int unsigned ChamferW       = 6;
  localparam int unsigned ColorW         = 16;
  localparam int unsigned PosW           = 10;
  localparam int unsigned SizeW          = 11;
  localparam int unsigned ScreenW        = 11;
  localparam int unsigned CoordW         = 14;
  localparam int unsigned CfgIdxW        = 1;
  localparam int unsigned ChamferNum     = 414;
  localparam int unsigned ChamferDen     = 1000;
  localparam int unsigned ScreenLimit    = 1024;
  localparam int unsigned ScreenWidthRst = 320;
  localparam int unsigned ScreenHeightRst = 240;

  typedef enum logic [CfgIdxW-1:0] {
    CfgScreenWidth  = 1'b0,
    CfgScreenHeight = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [ScreenW-1:0] width;
    logic [ScreenW-1:0] height;
  } screen_t;

  typedef struct packed {
    logic signed [CenterW-1:0] center_x;
    logic signed [CenterW-1:0] center_y;
    logic [RadiusW-1:0]        radius;
    logic [ChamferW-1:0]       chamfer;
    logic [RadiusW-1:0]        half;
    logic [ColorW-1:0]         fill_color;
  } job_t;

  typedef logic [ChamferW-1:0] chamfer_lut_t [0:MaxRadiusLimit];

  // Final chamfer per radius, already held between 1 and radius-1 (0 below radius 2).
  function automatic chamfer_lut_t chamfer_table();
    chamfer_lut_t t;
    int c;
    for (int i = 0; i <= int'(MaxRadiusLimit); i++) begin
      // floor(i * 414 / 1000): largest j with j * 1000 <= i * 414
      c = 0;
      for (int j = 1; j <= i; j++) begin
        if (j * int'(ChamferDen) <= i * int'(ChamferNum)) c = j;
      end
      if (c < 1) c = 1;
      if (c > i - 1) c = i - 1;
      if (c < 0) c = 0;
      t[i] = ChamferW'(c);
    end
    return t;
  endfunction

endpackage

/* rtl/ocsr_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Octagon span rasterizer channels
// Request channel (octagon in) and rectangle channel (spans out).
// ----------------------------------------------------------------------------
interface ocsr_req_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [ocsr_pkg::CenterW-1:0]       center_x;
  logic signed [ocsr_pkg::CenterW-1:0]       center_y;
  logic [ocsr_pkg::RadiusW-1:0]              radius;
  logic [ocsr_pkg::ColorW-1:0]               fill_color;

  modport source (output valid, center_x, center_y, radius, fill_color, input ready);
  modport sink   (input valid, center_x, center_y, radius, fill_color, output ready);
endinterface

interface ocsr_rect_if;
  logic                          valid;
  logic                          ready;
  logic [ocsr_pkg::PosW-1:0]     rect_x;
  logic [ocsr_pkg::PosW-1:0]     rect_y;
  logic [ocsr_pkg::SizeW-1:0]    rect_width;
  logic [ocsr_pkg::SizeW-1:0]    rect_height;
  logic [ocsr_pkg::ColorW-1:0]   rect_color;
  logic                          visible;
  logic                          last_rect;

  modport source (output valid, rect_x, rect_y, rect_width, rect_height, rect_color,
                  visible, last_rect, input ready);
  modport sink   (input valid, rect_x, rect_y, rect_width, rect_height, rect_color,
                  visible, last_rect, output ready);
endinterface

/* rtl/ocsr_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Octagon span rasterizer front end
// Accepts requests, clamps the radius, looks up the chamfer and derives band half.
// ----------------------------------------------------------------------------
module ocsr_front #(
  parameter int unsigned MAX_RADIUS = ocsr_pkg::MaxRadiusLimit
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  ocsr_req_if.sink           req,
  output logic               job_valid_o,
  output ocsr_pkg::job_t     job_o,
  input  logic               job_ready_i
);

  localparam int unsigned RW = ocsr_pkg::RadiusW;
  localparam ocsr_pkg::chamfer_lut_t ChamferLut = ocsr_pkg::chamfer_table();

  logic               valid_q;
  ocsr_pkg::job_t     job_q, job_d;
  logic [RW-1:0]      r_clamp;
  logic [ocsr_pkg::ChamferW-1:0] chamfer;
  logic               take;

  assign req.ready = !valid_q || job_ready_i;
  assign take      = req.valid && req.ready;

  always_comb begin
    if (req.radius == '0) begin
      r_clamp = RW'(1);
    end else if (req.radius > RW'(MAX_RADIUS)) begin
      r_clamp = RW'(MAX_RADIUS);
    end else begin
      r_clamp = req.radius;
    end
    chamfer          = ChamferLut[r_clamp];
    job_d.center_x   = req.center_x;
    job_d.center_y   = req.center_y;
    job_d.radius     = r_clamp;
    job_d.chamfer    = chamfer;
    job_d.half       = r_clamp - RW'(chamfer);
    job_d.fill_color = req.fill_color;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req.ready) begin
      valid_q <= req.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      job_q <= job_d;
    end
  end

  assign job_valid_o = valid_q;
  assign job_o       = job_q;

endmodule

/* rtl/ocsr_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Octagon span rasterizer job queue
// Two-entry queue between front end and span sequencer.
// ----------------------------------------------------------------------------
module ocsr_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  input  ocsr_pkg::job_t  push_job_i,
  output logic            push_ready_o,
  output logic            pop_valid_o,
  output ocsr_pkg::job_t  pop_job_o,
  input  logic            pop_i
);

  ocsr_pkg::job_t entry_q [0:1];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     count_q;
  logic           push, pop;

  assign push_ready_o = count_q != 2'd2;
  assign pop_valid_o  = count_q != 2'd0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_job_o    = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

/* rtl/ocsr_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Octagon span rasterizer back end
// Steps through the band and chamfer rows of one job, then clips each span.
// ----------------------------------------------------------------------------
module ocsr_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ocsr_pkg::screen_t screen_i,
  input  logic              job_valid_i,
  input  ocsr_pkg::job_t    job_i,
  output logic              job_pop_o,
  ocsr_rect_if.source       rect
);

  localparam int unsigned CW = ocsr_pkg::CoordW;
  localparam int unsigned RW = ocsr_pkg::RadiusW;
  localparam int unsigned KW = ocsr_pkg::ChamferW;

  // Sequencer
  logic [KW-1:0]       k_q, k_d;
  logic                bottom_q, bottom_d;
  logic                en, is_last;
  logic [RW-1:0]       rk;
  logic [RW:0]         hk;
  logic signed [CW-1:0] cx_s, cy_s, gx, gy, gw, gh;

  // Raw span stage
  logic                s1_valid_q;
  logic signed [CW-1:0] s1_x_q, s1_y_q, s1_w_q, s1_h_q;
  logic [ocsr_pkg::ColorW-1:0] s1_color_q;
  logic                s1_last_q;

  // Clip and output stage
  logic signed [CW-1:0] sw_s, sh_s, xl, yl, xe, ye, xr, yr, wc, hc;
  logic                vis;
  logic                out_valid_q;
  logic [ocsr_pkg::PosW-1:0]   out_x_q, out_y_q;
  logic [ocsr_pkg::SizeW-1:0]  out_w_q, out_h_q;
  logic [ocsr_pkg::ColorW-1:0] out_color_q;
  logic                out_vis_q, out_last_q;

  assign en = !out_valid_q || rect.ready;

  always_comb begin
    rk   = (k_q == '0) ? job_i.radius : job_i.radius - RW'(k_q);
    hk   = (RW+1)'(job_i.half) + (RW+1)'(k_q);
    cx_s = CW'(job_i.center_x);
    cy_s = CW'(job_i.center_y);
    gx   = cx_s - $signed(CW'(rk));
    gy   = bottom_q ? cy_s + $signed(CW'(hk)) : cy_s - $signed(CW'(hk));
    if (k_q == '0) begin
      gw = $signed(CW'({job_i.radius, 1'b0}));
      gh = $signed(CW'({job_i.half, 1'b1}));
    end else begin
      gw = $signed(CW'({rk, 1'b1}));
      gh = CW'(1);
    end
    is_last = (k_q == '0) ? (job_i.chamfer == '0) : (bottom_q && k_q == job_i.chamfer);
    // advance: band, then top and bottom row for each chamfer step
    k_d      = k_q;
    bottom_d = bottom_q;
    if (is_last) begin
      k_d      = '0;
      bottom_d = 1'b0;
    end else if (k_q == '0 || bottom_q) begin
      k_d      = k_q + KW'(1);
      bottom_d = 1'b0;
    end else begin
      bottom_d = 1'b1;
    end
  end

  assign job_pop_o = en && job_valid_i && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      bottom_q    <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= job_valid_i;
      out_valid_q <= s1_valid_q;
      if (job_valid_i) begin
        k_q      <= k_d;
        bottom_q <= bottom_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && job_valid_i) begin
      s1_x_q     <= gx;
      s1_y_q     <= gy;
      s1_w_q     <= gw;
      s1_h_q     <= gh;
      s1_color_q <= job_i.fill_color;
      s1_last_q  <= is_last;
    end
  end

  // Clip: span runs [max(x,0), min(x+w,screen)).
  always_comb begin
    sw_s = $signed(CW'(screen_i.width));
    sh_s = $signed(CW'(screen_i.height));
    xe   = s1_x_q + s1_w_q;
    ye   = s1_y_q + s1_h_q;
    xl   = (s1_x_q < 0) ? '0 : s1_x_q;
    yl   = (s1_y_q < 0) ? '0 : s1_y_q;
    xr   = (xe > sw_s) ? sw_s : xe;
    yr   = (ye > sh_s) ? sh_s : ye;
    wc   = xr - xl;
    hc   = yr - yl;
    vis  = (s1_w_q > 0) && (s1_h_q > 0) && (s1_x_q < sw_s) && (s1_y_q < sh_s) &&
           (xe > 0) && (ye > 0);
  end

  always_ff @(posedge clk_i) begin
    if (en && s1_valid_q) begin
      out_x_q     <= vis ? xl[ocsr_pkg::PosW-1:0] : '0;
      out_y_q     <= vis ? yl[ocsr_pkg::PosW-1:0] : '0;
      out_w_q     <= vis ? wc[ocsr_pkg::SizeW-1:0] : '0;
      out_h_q     <= vis ? hc[ocsr_pkg::SizeW-1:0] : '0;
      out_color_q <= s1_color_q;
      out_vis_q   <= vis;
      out_last_q  <= s1_last_q;
    end
  end

  assign rect.valid       = out_valid_q;
  assign rect.rect_x      = out_x_q;
  assign rect.rect_y      = out_y_q;
  assign rect.rect_width  = out_w_q;
  assign rect.rect_height = out_h_q;
  assign rect.rect_color  = out_color_q;
  assign rect.visible     = out_vis_q;
  assign rect.last_rect   = out_last_q;

endmodule

/* rtl/octagon_span_rasterizer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Octagon span rasterizer
// Turns one filled octagon request into the clipped screen spans that paint it.
// ----------------------------------------------------------------------------
//
//  channel   direction  carries                                   handshake
//  req_i     in         center_x, center_y, radius, fill_color    valid/ready
//  rect_o    out        rect_x/y, rect_width/height, rect_color,  valid/ready
//                       visible, last_rect
//  cfg       in         cfg_idx_i, cfg_data_i                      cfg_we_i
//
// One request gives 1+2c spans (c = chamfer, up to 26 at radius 64), one span
// per cycle from the span sequencer unless rect_o stalls; a taken request
// passes the front-end register, queue, raw span and output stages in turn.
// The front end and a two-entry queue take the next requests while spans of
// the current one are still going out. A stall on rect_o freezes the span
// pipeline in place; reset clears the queue and sequencer and loads the
// screen size registers with 320 x 240.
// ----------------------------------------------------------------------------
module octagon_span_rasterizer #(
  parameter int unsigned MAX_RADIUS = ocsr_pkg::MaxRadiusLimit
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  ocsr_req_if.sink                         req_i,
  ocsr_rect_if.source                      rect_o,
  input  logic                             cfg_we_i,
  input  logic [ocsr_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [ocsr_pkg::ScreenW-1:0]     cfg_data_i
);

  localparam int unsigned SW = ocsr_pkg::ScreenW;

  ocsr_pkg::screen_t screen_q;
  logic [SW-1:0]     cfg_clamped;
  logic              front_valid, front_ready;
  ocsr_pkg::job_t    front_job;
  logic              job_valid, job_pop;
  ocsr_pkg::job_t    job;

  // Hold screen size already clamped to 1..1024 so the clip stage sees it ready.
  always_comb begin
    if (cfg_data_i == '0) begin
      cfg_clamped = SW'(1);
    end else if (cfg_data_i > SW'(ocsr_pkg::ScreenLimit)) begin
      cfg_clamped = SW'(ocsr_pkg::ScreenLimit);
    end else begin
      cfg_clamped = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_q.width  <= SW'(ocsr_pkg::ScreenWidthRst);
      screen_q.height <= SW'(ocsr_pkg::ScreenHeightRst);
    end else if (cfg_we_i) begin
      case (ocsr_pkg::cfg_reg_e'(cfg_idx_i))
        ocsr_pkg::CfgScreenWidth:  screen_q.width  <= cfg_clamped;
        ocsr_pkg::CfgScreenHeight: screen_q.height <= cfg_clamped;
        default: ;
      endcase
    end
  end

  // Front end: clamp radius, look up chamfer, register one request.
  ocsr_front #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req_i),
    .job_valid_o (front_valid),
    .job_o       (front_job),
    .job_ready_i (front_ready)
  );

  // Decouple request intake from span output.
  ocsr_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_job_i   (front_job),
    .push_ready_o (front_ready),
    .pop_valid_o  (job_valid),
    .pop_job_o    (job),
    .pop_i        (job_pop)
  );

  // Back end: walk band and chamfer rows, clip, drive the rectangle channel.
  ocsr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .screen_i    (screen_q),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_pop_o   (job_pop),
    .rect        (rect_o)
  );

endmodule

/* tb/octagon_span_rasterizer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Octagon span rasterizer testbench
// Sends octagon requests through a directed table and then six random phases,
// one per screen size, and checks every rectangle against hand-written
// answers or a local model of the chamfer, span layout and screen clipping.
// ----------------------------------------------------------------------------
module octagon_span_rasterizer_tb;

  localparam int CycleLimit = 500000;
  localparam int LongHold   = 400;
  localparam int DirRows    = 21;
  localparam int PhaseItems = 20;
  localparam int BurstItems = 10;
  localparam int PosBits    = ocsr_pkg::PosW;
  localparam int SizeBits   = ocsr_pkg::SizeW;

  typedef struct packed {
    logic [ocsr_pkg::CenterW-1:0] cx;
    logic [ocsr_pkg::CenterW-1:0] cy;
    logic [ocsr_pkg::RadiusW-1:0] radius;
    logic [ocsr_pkg::ColorW-1:0]  color;
  } octagon_t;

  typedef struct packed {
    logic [ocsr_pkg::PosW-1:0]   x;
    logic [ocsr_pkg::PosW-1:0]   y;
    logic [ocsr_pkg::SizeW-1:0]  w;
    logic [ocsr_pkg::SizeW-1:0]  h;
    logic [ocsr_pkg::ColorW-1:0] color;
    logic                        vis;
    logic                        last;
  } rect_t;

  // typed = 1: the rectangle is written down by hand, not computed
  typedef struct packed {
    logic  typed;
    rect_t rect;
  } answer_t;

  typedef struct packed {
    octagon_t oct;
    logic     typed;
    rect_t    golden;
  } dir_row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [ocsr_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [ocsr_pkg::ScreenW-1:0]  cfg_data_i;

  ocsr_req_if  req_ch ();
  ocsr_rect_if rect_ch ();

  octagon_span_rasterizer u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_ch),
    .rect_o     (rect_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Shadow of the screen registers, as written (clamping happens at use).
  logic [ocsr_pkg::ScreenW-1:0] shadow_w = 11'(ocsr_pkg::ScreenWidthRst);
  logic [ocsr_pkg::ScreenW-1:0] shadow_h = 11'(ocsr_pkg::ScreenHeightRst);

  rect_t   pending_rects [$];
  answer_t answer_q [$];

  int send_idle_pct = 38;
  int recv_idle_pct = 64;
  int mismatches    = 0;
  int octagons_sent = 0;
  int rects_checked = 0;
  int rects_hidden  = 0;
  int cycle_cnt     = 0;

  logic long_hold_go   = 1'b0;
  logic long_hold_seen = 1'b0;
  int   hold_left      = 0;

  // Directed requests. Radius zero and one rows on the 320x240 reset screen
  // carry the answer by hand; the rest go through the model below.
  dir_row_t dir_table [DirRows] = '{
    // small octagon well inside the screen
    '{'{12'd100, 12'd50, 7'd1, 16'hF800}, 1'b1,
      '{10'd99, 10'd49, 11'd2, 11'd3, 16'hF800, 1'b1, 1'b1}},
    // radius zero acts as one, clipped at the origin corner
    '{'{12'd0, 12'd0, 7'd0, 16'h0000}, 1'b1,
      '{10'd0, 10'd0, 11'd1, 11'd2, 16'h0000, 1'b1, 1'b1}},
    // most negative centre: clipped away, colour and last still carried
    '{'{12'h800, 12'h800, 7'd1, 16'hFFFF}, 1'b1,
      '{10'd0, 10'd0, 11'd0, 11'd0, 16'hFFFF, 1'b0, 1'b1}},
    // most positive centre: clipped away
    '{'{12'h7FF, 12'h7FF, 7'd1, 16'h07E0}, 1'b1,
      '{10'd0, 10'd0, 11'd0, 11'd0, 16'h07E0, 1'b0, 1'b1}},
    // bottom-right pixel corner
    '{'{12'd319, 12'd239, 7'd1, 16'h001F}, 1'b1,
      '{10'd318, 10'd238, 11'd2, 11'd2, 16'h001F, 1'b1, 1'b1}},
    // right edge lands exactly on column zero: hidden
    '{'{12'hFFF, 12'd120, 7'd1, 16'hAAAA}, 1'b1,
      '{10'd0, 10'd0, 11'd0, 11'd0, 16'hAAAA, 1'b0, 1'b1}},
    '{'{12'd160, 12'd120, 7'd2,   16'h5555}, 1'b0, '0},
    '{'{12'd160, 12'd120, 7'd3,   16'h1234}, 1'b0, '0},
    '{'{12'd160, 12'd120, 7'd4,   16'h0001}, 1'b0, '0},
    '{'{12'd160, 12'd120, 7'd64,  16'hFFFF}, 1'b0, '0},
    '{'{12'd160, 12'd120, 7'd127, 16'h0000}, 1'b0, '0},
    '{'{12'd160, 12'd120, 7'd65,  16'h8001}, 1'b0, '0},
    '{'{12'd0,   12'd0,   7'd64,  16'hF0F0}, 1'b0, '0},
    '{'{12'd319, 12'd239, 7'd64,  16'h0F0F}, 1'b0, '0},
    '{'{12'hFC1, 12'd120, 7'd64,  16'hC3C3}, 1'b0, '0},
    '{'{12'hFC0, 12'd120, 7'd64,  16'h3C3C}, 1'b0, '0},
    '{'{12'd100, 12'hFE2, 7'd20,  16'h7777}, 1'b0, '0},
    '{'{12'd330, 12'd100, 7'd20,  16'h1111}, 1'b0, '0},
    '{'{12'h7FF, 12'h800, 7'd64,  16'h2222}, 1'b0, '0},
    '{'{12'h800, 12'h7FF, 7'd100, 16'h4444}, 1'b0, '0},
    '{'{12'd160, 12'd250, 7'd40,  16'h9999}, 1'b0, '0}
  };

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Give up on a hang.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("Timed out after %0d cycles with %0d rectangles outstanding",
               cycle_cnt, pending_rects.size());
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int screen_limit(logic [ocsr_pkg::ScreenW-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > int'(ocsr_pkg::ScreenLimit)) return int'(ocsr_pkg::ScreenLimit);
    return int'(v);
  endfunction

  // Clip one span against the screen and queue the rectangle it leaves.
  function automatic void clip_span(int x, int y, int w, int h,
                                    logic [ocsr_pkg::ColorW-1:0] color, logic last);
    int    sw;
    int    sh;
    logic  vis;
    rect_t r;
    sw  = screen_limit(shadow_w);
    sh  = screen_limit(shadow_h);
    vis = 1'b1;
    if (w <= 0 || h <= 0 || x >= sw || y >= sh || x + w <= 0 || y + h <= 0) begin
      vis = 1'b0;
    end else begin
      if (x < 0) begin
        w += x;
        x = 0;
      end
      if (y < 0) begin
        h += y;
        y = 0;
      end
      if (x + w > sw) w = sw - x;
      if (y + h > sh) h = sh - y;
      if (w <= 0 || h <= 0) vis = 1'b0;
    end
    if (!vis) begin
      x = 0;
      y = 0;
      w = 0;
      h = 0;
    end
    r.x     = PosBits'(x);
    r.y     = PosBits'(y);
    r.w     = SizeBits'(w);
    r.h     = SizeBits'(h);
    r.color = color;
    r.vis   = vis;
    r.last  = last;
    pending_rects.push_back(r);
  endfunction

  // Middle band first, then a top and a bottom row for every chamfer step.
  function automatic void paint_octagon(octagon_t o);
    int cx;
    int cy;
    int r;
    int c;
    int half;
    cx = int'($signed(o.cx));
    cy = int'($signed(o.cy));
    r  = int'(o.radius);
    if (r < 1) r = 1;
    if (r > int'(ocsr_pkg::MaxRadiusLimit)) r = int'(ocsr_pkg::MaxRadiusLimit);
    c = (r * int'(ocsr_pkg::ChamferNum)) / int'(ocsr_pkg::ChamferDen);
    if (c < 1) c = 1;
    if (c > r - 1) c = r - 1;
    half = r - c;
    clip_span(cx - r, cy - half, 2 * r, 2 * half + 1, o.color, c == 0);
    for (int k = 1; k <= c; k++) begin
      clip_span(cx - (r - k), cy - half - k, 2 * (r - k) + 1, 1, o.color, 1'b0);
      clip_span(cx - (r - k), cy + half + k, 2 * (r - k) + 1, 1, o.color, k == c);
    end
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Predict on every accepted request, then compare every accepted
  // rectangle with the oldest one still waiting. Both handshakes are read
  // with their values from before the edge.
  always @(posedge clk_i) begin : scoreboard
    answer_t  ans;
    octagon_t o;
    rect_t    want;
    rect_t    got;
    if (rst_ni) begin
      if (req_ch.valid && req_ch.ready) begin
        ans      = answer_q.pop_front();
        o.cx     = req_ch.center_x;
        o.cy     = req_ch.center_y;
        o.radius = req_ch.radius;
        o.color  = req_ch.fill_color;
        if (ans.typed) pending_rects.push_back(ans.rect);
        else paint_octagon(o);
      end
      if (rect_ch.valid && rect_ch.ready) begin
        got.x     = rect_ch.rect_x;
        got.y     = rect_ch.rect_y;
        got.w     = rect_ch.rect_width;
        got.h     = rect_ch.rect_height;
        got.color = rect_ch.rect_color;
        got.vis   = rect_ch.visible;
        got.last  = rect_ch.last_rect;
        rects_checked++;
        if (!got.vis) rects_hidden++;
        if (pending_rects.size() == 0) begin
          mismatches++;
          $display("%0t: rectangle with none expected, got x=%0d y=%0d w=%0d h=%0d",
                   $time, got.x, got.y, got.w, got.h);
        end else begin
          want = pending_rects.pop_front();
          check_field("rect_x", want.x, got.x);
          check_field("rect_y", want.y, got.y);
          check_field("rect_width", want.w, got.w);
          check_field("rect_height", want.h, got.h);
          check_field("rect_color", want.color, got.color);
          check_field("visible", want.vis, got.vis);
          check_field("last_rect", want.last, got.last);
        end
      end
    end
  end

  // Rectangle sink: random back-pressure, plus one long hold on request.
  always @(posedge clk_i) begin
    if (long_hold_go && !long_hold_seen) begin
      long_hold_seen = 1'b1;
      hold_left      = LongHold;
    end
    if (hold_left > 0) begin
      hold_left--;
      rect_ch.ready <= 1'b0;
    end else begin
      rect_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one request, idling first at the current rate, and return in the
  // time step of its acceptance with valid still high.
  task automatic send_octagon(input octagon_t oct, input logic typed, input rect_t want);
    answer_t ans;
    if ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    ans.typed = typed;
    ans.rect  = want;
    answer_q.push_back(ans);
    req_ch.valid      <= 1'b1;
    req_ch.center_x   <= oct.cx;
    req_ch.center_y   <= oct.cy;
    req_ch.radius     <= oct.radius;
    req_ch.fill_color <= oct.color;
    do @(posedge clk_i); while (!req_ch.ready);
    octagons_sent++;
  endtask

  // Drop valid and hold off until every expected rectangle has arrived.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (pending_rects.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Write both screen registers back to back; only called while idle.
  task automatic set_screen(input logic [ocsr_pkg::ScreenW-1:0] w,
                            input logic [ocsr_pkg::ScreenW-1:0] h);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= ocsr_pkg::CfgScreenWidth;
    cfg_data_i <= w;
    @(posedge clk_i);
    cfg_idx_i  <= ocsr_pkg::CfgScreenHeight;
    cfg_data_i <= h;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    shadow_w = w;
    shadow_h = h;
  endtask

  // Mostly small octagons near the screen, some large or out-of-range radii
  // and some centres anywhere in the 12-bit range.
  function automatic octagon_t random_octagon();
    octagon_t o;
    int       sw;
    int       sh;
    int       pick;
    sw   = screen_limit(shadow_w);
    sh   = screen_limit(shadow_h);
    pick = int'($urandom_range(99));
    if (pick < 60)      o.radius = 7'($urandom_range(1, 12));
    else if (pick < 85) o.radius = 7'($urandom_range(13, 64));
    else if (pick < 96) o.radius = 7'($urandom_range(65, 127));
    else                o.radius = 7'd0;
    if ($urandom_range(7) == 0) o.cx = 12'($urandom_range(4095));
    else o.cx = 12'(int'($urandom_range(sw + 140)) - 70);
    if ($urandom_range(7) == 0) o.cy = 12'($urandom_range(4095));
    else o.cy = 12'(int'($urandom_range(sh + 140)) - 70);
    o.color = 16'($urandom_range(65535));
    return o;
  endfunction

  initial begin : stimulus
    logic [ocsr_pkg::ScreenW-1:0] phase_w [6];
    logic [ocsr_pkg::ScreenW-1:0] phase_h [6];
    int                           saved_pct;
    phase_w = '{11'd320, 11'd1, 11'd1024, 11'd0, 11'd2047, 11'd0};
    phase_h = '{11'd240, 11'd1, 11'd1024, 11'd0, 11'd1025, 11'd0};

    // Hold every request-side input at a known value through reset.
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= ocsr_pkg::CfgScreenWidth;
    cfg_data_i        <= '0;
    req_ch.valid      <= 1'b0;
    req_ch.center_x   <= '0;
    req_ch.center_y   <= '0;
    req_ch.radius     <= '0;
    req_ch.fill_color <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part on the reset screen size.
    for (int i = 0; i < DirRows; i++) begin
      send_octagon(dir_table[i].oct, dir_table[i].typed, dir_table[i].golden);
    end
    wait_drained();

    // Random part: a new screen size per phase, idle mix changing every two
    // phases (sender-heavy, receiver-heavy, then none).
    for (int phase = 0; phase < 6; phase++) begin
      case (phase / 2)
        0: begin
          send_idle_pct = 38;
          recv_idle_pct = 64;
        end
        1: begin
          send_idle_pct = 64;
          recv_idle_pct = 38;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (phase == 5) set_screen(11'($urandom_range(1, 1024)), 11'($urandom_range(1, 1024)));
      else set_screen(phase_w[phase], phase_h[phase]);
      for (int n = 0; n < PhaseItems; n++) begin
        send_octagon(random_octagon(), 1'b0, '0);
      end
      // Stall the rectangle side for a long stretch and keep pushing
      // requests back to back so the input queue fills and backs up.
      if (phase == 2) begin
        long_hold_go <= 1'b1;
        saved_pct     = send_idle_pct;
        send_idle_pct = 0;
        for (int n = 0; n < BurstItems; n++) begin
          send_octagon(random_octagon(), 1'b0, '0);
        end
        send_idle_pct = saved_pct;
      end
      wait_drained();
    end

    // Let any stray rectangle show up before judging.
    repeat (16) @(posedge clk_i);
    $display("Sent %0d octagons: %0d directed, the rest random over six screen sizes",
             octagons_sent, DirRows);
    $display("Checked %0d rectangles, %0d clipped away, in %0d cycles",
             rects_checked, rects_hidden, cycle_cnt);
    if (mismatches == 0 && pending_rects.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
